>>> sv/pfba_pkg.sv
// shared types and constants for the physical frame bump allocator
package pfba_pkg;

    localparam int FRAME_W    = 40;
    localparam int NF_W       = FRAME_W + 1;
    localparam int ADDR_W     = 52;
    localparam int ALU_W      = ADDR_W + 1;
    localparam int PAGE_SHIFT = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 40;
    localparam int COUNT_W    = 5;

    localparam logic [FRAME_W-1:0] FRAME_MAX   = '1;
    localparam logic [7:0]         USABLE_CODE = 8'd1;

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_INIT  = 2'd1;
    localparam logic [1:0] CMD_ALLOC = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_REGION_COUNT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_FIRST  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_LAST   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BOOTINFO_FIRST = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BOOTINFO_LAST = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LD_DEC,
        ST_LD_WR,
        ST_SC_RD,
        ST_SC_CMP,
        ST_SC_START,
        ST_AL_CHK,
        ST_AL_KLO,
        ST_AL_KHI,
        ST_AL_BLO,
        ST_AL_BHI,
        ST_AL_MIN,
        ST_AL_INC,
        ST_AL_GRANT,
        ST_DONE
    } pfba_state_t;

    // adder control: sub gives a - b with carry meaning a >= b, inc adds one
    typedef struct packed {
        logic sub;
        logic inc;
    } alu_op_t;

    typedef struct packed {
        logic               usable;
        logic               empty;
        logic [FRAME_W-1:0] first_frame;
        logic [FRAME_W-1:0] last_frame;
    } slot_t;

endpackage

>>> sv/physical_frame_bump_allocator_unit.sv
// top level of the physical frame bump allocator
// Hands out 4 KiB frames in ascending order from a table of memory regions.
// A load item passes through ST_LD_DEC and ST_LD_WR and stores the region's
// first and last frame, both worked out at load time. An allocate item
// grants the next frame when the current region has it free; every skip over
// the kernel or boot-info range goes through ST_AL_MIN and ST_AL_INC, and
// moving to another region rescans the table from slot 0, slot by slot.
// An init item scans the table the same way. All of these run one
// step at a time through a single shared 53-bit adder/comparator, and the slot
// table has one registered read port. The input is stalled while an item is in
// work; a result waits in an output register, so the next item can be taken
// before it is transferred. Configuration is always ready.
module physical_frame_bump_allocator_unit #(
    parameter int REGION_SLOTS = 16,
    parameter int ADDR_BITS    = 52
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        cmd,
    input  logic [3:0]                        slot_index,
    input  logic [7:0]                        region_type,
    input  logic [pfba_pkg::ADDR_W-1:0]       region_base,
    input  logic [pfba_pkg::ADDR_W-1:0]       region_length,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [pfba_pkg::FRAME_W-1:0]      frame_number,
    output logic                              granted,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pfba_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pfba_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import pfba_pkg::*;

    localparam int IW = (REGION_SLOTS > 1) ? $clog2(REGION_SLOTS) : 1;
    localparam int CW = $clog2(REGION_SLOTS + 1);
    localparam logic [ADDR_W-1:0] ADDR_MASK =
        (ADDR_BITS >= ADDR_W) ? {ADDR_W{1'b1}} :
        ((ADDR_W'(1) << ADDR_BITS) - ADDR_W'(1));

    // configuration
    logic [COUNT_W-1:0] region_count_reg;
    logic [FRAME_W-1:0] kernel_first_reg;
    logic [FRAME_W-1:0] kernel_last_reg;
    logic [FRAME_W-1:0] boot_first_reg;
    logic [FRAME_W-1:0] boot_last_reg;

    // control
    pfba_state_t        state_reg, state_next;
    logic [FRAME_W-1:0] next_frame_reg, next_frame_next;
    logic [IW-1:0]      area_index_reg, area_index_next;
    logic               area_valid_reg, area_valid_next;
    logic               out_valid_reg, out_valid_next;

    // working registers
    logic [NF_W-1:0]    nf_reg, nf_next;
    logic [ALU_W-1:0]   acc_reg, acc_next;
    logic [CW-1:0]      scan_reg, scan_next;
    logic               alloc_reg, alloc_next;
    logic               skip_kernel_reg, skip_kernel_next;
    logic [FRAME_W-1:0] res_frame_reg, res_frame_next;
    logic               res_granted_reg, res_granted_next;
    logic [IW-1:0]      addr_reg, rd_addr;
    logic [FRAME_W-1:0] frame_number_reg, frame_number_next;
    logic               granted_reg, granted_next;

    // load item latches
    logic [IW-1:0]      ld_slot_reg;
    logic               ld_ok_reg;
    logic               ld_usable_reg;
    logic [ADDR_W-1:0]  ld_base_reg;
    logic [ADDR_W-1:0]  ld_len_reg;

    // slot table
    slot_t              slot_mem [REGION_SLOTS];
    slot_t              rd_data_reg;
    slot_t              wr_data;

    // shared unit
    alu_op_t            alu_op;
    logic [ALU_W-1:0]   alu_a, alu_b, alu_sum;
    logic               alu_carry;

    logic               in_accept;
    logic               out_free;
    logic [CW-1:0]      scan_limit;
    logic [FRAME_W-1:0] skip_limit;
    logic [FRAME_W-1:0] nf_clip;

    pfba_alu u_alu (
        .op    (alu_op),
        .a     (alu_a),
        .b     (alu_b),
        .sum   (alu_sum),
        .carry (alu_carry)
    );

    assign in_stall   = (state_reg != ST_IDLE);
    assign in_accept  = in_valid && !in_stall;
    assign out_free   = !out_valid_reg || !out_stall;
    assign cfg_ready  = 1'b1;
    assign scan_limit = (int'(region_count_reg) > REGION_SLOTS) ?
                        CW'(REGION_SLOTS) : CW'(region_count_reg);
    assign skip_limit = skip_kernel_reg ? kernel_last_reg : boot_last_reg;
    assign nf_clip    = nf_reg[FRAME_W] ? FRAME_MAX : nf_reg[FRAME_W-1:0];

    assign out_valid    = out_valid_reg;
    assign frame_number = frame_number_reg;
    assign granted      = granted_reg;

    // operand selection for the shared unit
    always_comb
    begin
        alu_op = '0;
        alu_a  = '0;
        alu_b  = '0;
        unique case (state_reg)
            ST_LD_DEC:
            begin
                alu_op.sub = 1'b1;
                alu_a      = {1'b0, ld_len_reg};
                alu_b      = ALU_W'(1);
            end
            ST_LD_WR:
            begin
                alu_a = {1'b0, ld_base_reg};
                alu_b = acc_reg;
            end
            ST_SC_CMP, ST_AL_CHK:
            begin
                alu_op.sub = 1'b1;
                alu_a      = ALU_W'(rd_data_reg.last_frame);
                alu_b      = ALU_W'(nf_reg);
            end
            ST_SC_START:
            begin
                alu_op.sub = 1'b1;
                alu_a      = ALU_W'(nf_reg);
                alu_b      = ALU_W'(rd_data_reg.first_frame);
            end
            ST_AL_KLO:
            begin
                alu_op.sub = 1'b1;
                alu_a      = ALU_W'(nf_reg);
                alu_b      = ALU_W'(kernel_first_reg);
            end
            ST_AL_KHI:
            begin
                alu_op.sub = 1'b1;
                alu_a      = ALU_W'(kernel_last_reg);
                alu_b      = ALU_W'(nf_reg);
            end
            ST_AL_BLO:
            begin
                alu_op.sub = 1'b1;
                alu_a      = ALU_W'(nf_reg);
                alu_b      = ALU_W'(boot_first_reg);
            end
            ST_AL_BHI:
            begin
                alu_op.sub = 1'b1;
                alu_a      = ALU_W'(boot_last_reg);
                alu_b      = ALU_W'(nf_reg);
            end
            ST_AL_MIN:
            begin
                alu_op.sub = 1'b1;
                alu_a      = ALU_W'(rd_data_reg.last_frame);
                alu_b      = ALU_W'(skip_limit);
            end
            ST_AL_INC, ST_AL_GRANT:
            begin
                alu_op.inc = 1'b1;
                alu_a      = ALU_W'(nf_reg);
            end
            default:
            begin
                alu_op = '0;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (cmd == CMD_LOAD)
                        state_next = ST_LD_DEC;
                    else if (cmd == CMD_INIT)
                        state_next = ST_SC_RD;
                    else if (cmd == CMD_ALLOC)
                        state_next = area_valid_reg ? ST_AL_CHK : ST_DONE;
                end
            end
            ST_LD_DEC:   state_next = ST_LD_WR;
            ST_LD_WR:    state_next = ST_IDLE;
            ST_SC_RD:    state_next = (scan_reg >= scan_limit) ? ST_DONE : ST_SC_CMP;
            ST_SC_CMP:
            begin
                if (rd_data_reg.usable && !rd_data_reg.empty && alu_carry)
                    state_next = ST_SC_START;
                else
                    state_next = ST_SC_RD;
            end
            ST_SC_START: state_next = alloc_reg ? ST_AL_CHK : ST_DONE;
            ST_AL_CHK:
            begin
                if (rd_data_reg.empty || !alu_carry)
                    state_next = ST_SC_RD;
                else
                    state_next = ST_AL_KLO;
            end
            ST_AL_KLO:   state_next = alu_carry ? ST_AL_KHI : ST_AL_BLO;
            ST_AL_KHI:   state_next = alu_carry ? ST_AL_MIN : ST_AL_BLO;
            ST_AL_BLO:   state_next = alu_carry ? ST_AL_BHI : ST_AL_GRANT;
            ST_AL_BHI:   state_next = alu_carry ? ST_AL_MIN : ST_AL_GRANT;
            ST_AL_MIN:   state_next = ST_AL_INC;
            ST_AL_INC:   state_next = ST_AL_CHK;
            ST_AL_GRANT: state_next = ST_DONE;
            ST_DONE:
            begin
                if (!alloc_reg || out_free)
                    state_next = ST_IDLE;
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        next_frame_next   = next_frame_reg;
        area_index_next   = area_index_reg;
        area_valid_next   = area_valid_reg;
        nf_next           = nf_reg;
        acc_next          = acc_reg;
        scan_next         = scan_reg;
        alloc_next        = alloc_reg;
        skip_kernel_next  = skip_kernel_reg;
        res_frame_next    = res_frame_reg;
        res_granted_next  = res_granted_reg;
        rd_addr           = addr_reg;
        out_valid_next    = out_valid_reg && out_stall;
        frame_number_next = frame_number_reg;
        granted_next      = granted_reg;

        wr_data.usable      = ld_usable_reg;
        wr_data.empty       = (ld_len_reg == '0);
        wr_data.first_frame = ld_base_reg[ADDR_W-1:PAGE_SHIFT];
        // end address past 52 bits clips to the largest frame
        wr_data.last_frame  = alu_sum[ALU_W-1] ? FRAME_MAX :
                              alu_sum[ALU_W-2:PAGE_SHIFT];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && cmd == CMD_INIT)
                begin
                    nf_next    = '0;
                    scan_next  = '0;
                    alloc_next = 1'b0;
                end
                else if (in_accept && cmd == CMD_ALLOC)
                begin
                    nf_next          = {1'b0, next_frame_reg};
                    alloc_next       = 1'b1;
                    res_frame_next   = '0;
                    res_granted_next = 1'b0;
                    rd_addr          = area_index_reg;
                end
            end
            ST_LD_DEC:
            begin
                acc_next = alu_sum;
            end
            ST_SC_RD:
            begin
                if (scan_reg >= scan_limit)
                    area_valid_next = 1'b0;
                else
                    rd_addr = scan_reg[IW-1:0];
            end
            ST_SC_CMP:
            begin
                if (rd_data_reg.usable && !rd_data_reg.empty && alu_carry)
                begin
                    area_index_next = scan_reg[IW-1:0];
                    area_valid_next = 1'b1;
                end
                else
                begin
                    scan_next = scan_reg + CW'(1);
                end
            end
            ST_SC_START:
            begin
                if (!alu_carry)
                    nf_next = NF_W'(rd_data_reg.first_frame);
            end
            ST_AL_CHK:
            begin
                // current region used up: rescan from the first slot
                if (rd_data_reg.empty || !alu_carry)
                    scan_next = '0;
            end
            ST_AL_KHI:
            begin
                skip_kernel_next = 1'b1;
            end
            ST_AL_BHI:
            begin
                skip_kernel_next = 1'b0;
            end
            ST_AL_MIN:
            begin
                // jump to just past the reserved range, not past the region
                nf_next = alu_carry ? NF_W'(skip_limit) :
                          NF_W'(rd_data_reg.last_frame);
            end
            ST_AL_INC:
            begin
                nf_next = alu_sum[NF_W-1:0];
            end
            ST_AL_GRANT:
            begin
                res_frame_next   = nf_reg[FRAME_W-1:0];
                res_granted_next = 1'b1;
                nf_next          = alu_sum[NF_W-1:0];
                if (alu_sum[FRAME_W])
                    area_valid_next = 1'b0;
            end
            ST_DONE:
            begin
                if (!alloc_reg || out_free)
                    next_frame_next = nf_clip;
                if (alloc_reg && out_free)
                begin
                    out_valid_next    = 1'b1;
                    frame_number_next = res_frame_reg;
                    granted_next      = res_granted_reg;
                end
            end
            default:
            begin
                acc_next = acc_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            next_frame_reg   <= '0;
            area_index_reg   <= '0;
            area_valid_reg   <= 1'b0;
            out_valid_reg    <= 1'b0;
            region_count_reg <= '0;
            kernel_first_reg <= '0;
            kernel_last_reg  <= '0;
            boot_first_reg   <= '0;
            boot_last_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            next_frame_reg <= next_frame_next;
            area_index_reg <= area_index_next;
            area_valid_reg <= area_valid_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_REGION_COUNT:   region_count_reg <= cfg_data[COUNT_W-1:0];
                    REG_KERNEL_FIRST:   kernel_first_reg <= cfg_data[FRAME_W-1:0];
                    REG_KERNEL_LAST:    kernel_last_reg  <= cfg_data[FRAME_W-1:0];
                    REG_BOOTINFO_FIRST: boot_first_reg   <= cfg_data[FRAME_W-1:0];
                    REG_BOOTINFO_LAST:  boot_last_reg    <= cfg_data[FRAME_W-1:0];
                    default:            region_count_reg <= region_count_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        nf_reg           <= nf_next;
        acc_reg          <= acc_next;
        scan_reg         <= scan_next;
        alloc_reg        <= alloc_next;
        skip_kernel_reg  <= skip_kernel_next;
        res_frame_reg    <= res_frame_next;
        res_granted_reg  <= res_granted_next;
        addr_reg         <= rd_addr;
        frame_number_reg <= frame_number_next;
        granted_reg      <= granted_next;
        if (in_accept && cmd == CMD_LOAD)
        begin
            ld_slot_reg   <= IW'(slot_index);
            ld_ok_reg     <= (int'(slot_index) < REGION_SLOTS);
            ld_usable_reg <= (region_type == USABLE_CODE);
            ld_base_reg   <= region_base & ADDR_MASK;
            ld_len_reg    <= region_length & ADDR_MASK;
        end
    end

    // slot table, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_LD_WR && ld_ok_reg)
            slot_mem[ld_slot_reg] <= wr_data;
        rd_data_reg <= slot_mem[rd_addr];
    end

    // a result only appears after an allocate item finishes
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == ST_DONE) && $past(alloc_reg))
        else $error("result without a finished allocate item");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !granted |-> frame_number == '0)
        else $error("refused allocation carries a nonzero frame");

    // a finished allocate item waits for the output register
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DONE && alloc_reg && out_valid && out_stall
        |=> state_reg == ST_DONE)
        else $error("result dropped while output stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && cmd == CMD_ALLOC |=> state_reg != ST_IDLE)
        else $error("allocate item finished without a result");

endmodule

>>> sv/pfba_alu.sv
// shared add, subtract and compare unit of the frame allocator
module pfba_alu (
    input  pfba_pkg::alu_op_t              op,
    input  logic [pfba_pkg::ALU_W-1:0]     a,
    input  logic [pfba_pkg::ALU_W-1:0]     b,
    output logic [pfba_pkg::ALU_W-1:0]     sum,
    output logic                           carry
);
    import pfba_pkg::*;

    logic [ALU_W:0]   total;
    logic [ALU_W-1:0] b_in;

    always_comb
    begin
        b_in  = op.sub ? ~b : b;
        total = {1'b0, a} + {1'b0, b_in} + {{ALU_W{1'b0}}, op.sub | op.inc};
        sum   = total[ALU_W-1:0];
        carry = total[ALU_W];
    end

endmodule
